// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL files (pose_velocity_tracker)
// All checks are sampled on aclk and switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PVT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PVT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pvt_pkg.sv
// ----------------------------------------------------------------------------
// pvt_pkg
// Constants, codes and types of the pose and velocity tracker.
// ----------------------------------------------------------------------------
package pvt_pkg;

    // Fixed point format
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int POS_W   = 32;
    localparam int THETA_W = 21;
    localparam int HEAD_W  = 19;
    localparam int SPEED_W = 31;
    localparam int VEL_W   = 32;
    localparam int DT_W    = 32;

    // Heading arithmetic width (wrap loop)
    localparam int WRAP_W = 32;

    // pi in Q32, rounded to FRAC_BITS
    localparam longint PI_Q32  = 64'sd13493037705;
    localparam longint PI_FULL = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam logic signed [WRAP_W-1:0] PI_FIX     = WRAP_W'(PI_FULL);
    localparam logic signed [WRAP_W-1:0] TWO_PI_FIX = WRAP_W'(2 * PI_FULL);
    localparam logic signed [WRAP_W-1:0] PI_LO      = WRAP_W'(1 - PI_FULL);

    // Rate scale: microseconds to seconds
    localparam logic [31:0] RATE_SCALE = 32'd1000000;

    // Shared subtractor width (square root remainder is the widest user)
    localparam int SUB_W = 36;

    // Square root runs over 33 bit pairs, division over 32 quotient bits
    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS  = 6'd31;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_MOVE   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Rate jobs, run in this order
    typedef enum logic [1:0] {
        JOB_SPEED = 2'd0,
        JOB_VX    = 2'd1,
        JOB_VY    = 2'd2,
        JOB_TURN  = 2'd3
    } job_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_DIFF,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ADD,
        ST_SQRT,
        ST_SCALE,
        ST_LOAD,
        ST_OVF,
        ST_DIV,
        ST_STORE,
        ST_COMMIT,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/pose_velocity_tracker.sv
// ----------------------------------------------------------------------------
// pose_velocity_tracker
// Tracks a planar pose and its velocities in fixed point, one request at a time.
// ----------------------------------------------------------------------------
// Input channel s_*: one request carries func, new_x, new_y, new_theta and
// dt_us. The heading is wrapped into ]-pi, pi] before use.
// Result channel m_*: one result per request, showing the state after it.
// func 0 with nonzero dt_us runs a rate update through one shared 33x32
// multiplier and one shared 36-bit subtractor under a sequencer: sum of
// squares (square x, square y, add), a 33-step square root, then four rate
// jobs (speed, x and y velocity, heading rate), each with the steps scale,
// round, overflow check, 32-step division, store; a job whose quotient
// overflows skips the division. The heading wrap folds by 2*pi once per
// step, up to 3 times, until the heading is in range.
// s_ready is high only while idle, so one request is in flight at a time and
// the next one is taken at the earliest in the cycle after the result is
// accepted.
// A stalled result (m_ready low) holds m_valid and the payload; no new
// request is taken until it is accepted.
// Reset (aresetn low, synchronous) clears the pose and velocities to zero
// and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pose_velocity_tracker
    import pvt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_func,
    input  logic signed [POS_W-1:0]   s_new_x,
    input  logic signed [POS_W-1:0]   s_new_y,
    input  logic signed [THETA_W-1:0] s_new_theta,
    input  logic [DT_W-1:0]           s_dt_us,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [POS_W-1:0]   m_pos_x_out,
    output logic signed [POS_W-1:0]   m_pos_y_out,
    output logic signed [HEAD_W-1:0]  m_heading_out,
    output logic [SPEED_W-1:0]        m_speed_out,
    output logic signed [VEL_W-1:0]   m_vel_x_out,
    output logic signed [VEL_W-1:0]   m_vel_y_out,
    output logic signed [VEL_W-1:0]   m_turn_rate_out,
    output logic                      m_zero_dt_error
);

    // Sequencer
    state_t state_reg, state_next;
    job_t   job_reg;
    logic [5:0] cnt_reg;

    // Latched request
    func_t                     func_reg;
    logic signed [POS_W-1:0]   nx_reg;
    logic signed [POS_W-1:0]   ny_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [WRAP_W-1:0]  t_reg;
    logic signed [POS_W:0]     dx_reg;
    logic signed [POS_W:0]     dy_reg;
    logic signed [HEAD_W:0]    dth_reg;

    // Pose and velocity state
    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic signed [VEL_W-1:0]   vel_x_reg;
    logic signed [VEL_W-1:0]   vel_y_reg;
    logic signed [VEL_W-1:0]   turn_reg;
    logic                      err_reg;

    // Shared arithmetic datapath
    logic [64:0]       prod_reg;
    logic [65:0]       sh_reg;
    logic [SUB_W-1:0]  rem_reg;
    logic [32:0]       root_reg;
    logic [31:0]       q_reg;
    logic              ovf_reg;

    logic [32:0]       mul_a;
    logic [31:0]       mul_b;
    logic [64:0]       mul_p;
    logic [SUB_W-1:0]  sub_a;
    logic [SUB_W-1:0]  sub_b;
    logic [SUB_W:0]    sub_diff;
    logic              sub_borrow;

    // Magnitudes and signs of the rate jobs
    logic [32:0]       dx_abs;
    logic [32:0]       dy_abs;
    logic [HEAD_W:0]   dth_abs;
    logic [32:0]       job_mag;
    logic              job_neg;
    logic [31:0]       sat_signed;
    logic [53:0]       num_rounded;
    logic              update_path;

    assign dx_abs  = dx_reg[POS_W] ? (33'd0 - dx_reg) : dx_reg;
    assign dy_abs  = dy_reg[POS_W] ? (33'd0 - dy_reg) : dy_reg;
    assign dth_abs = dth_reg[HEAD_W] ? (20'd0 - dth_reg) : dth_reg;

    always_comb begin
        unique case (job_reg)
            JOB_SPEED: begin
                job_mag = root_reg;
                job_neg = 1'b0;
            end
            JOB_VX: begin
                job_mag = {1'b0, dx_abs[31:0]};
                job_neg = dx_reg[POS_W];
            end
            JOB_VY: begin
                job_mag = {1'b0, dy_abs[31:0]};
                job_neg = dy_reg[POS_W];
            end
            JOB_TURN: begin
                job_mag = 33'(dth_abs);
                job_neg = dth_reg[HEAD_W];
            end
            default: begin
                job_mag = '0;
                job_neg = 1'b0;
            end
        endcase
    end

    // Shared units
    assign mul_p      = 65'(mul_a) * 65'(mul_b);
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[SUB_W];

    // Rounded numerator: |d| * 1e6 + dt/2 (fits in 54 bits)
    assign num_rounded = prod_reg[53:0] + {23'd0, dt_reg[DT_W-1:1]};

    // Saturated signed rate from quotient, overflow flag and sign
    always_comb begin
        if (job_neg) begin
            sat_signed = (ovf_reg || q_reg > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_reg);
        end else begin
            sat_signed = (ovf_reg || q_reg[31]) ? 32'h7FFF_FFFF : q_reg;
        end
    end

    assign update_path = (func_reg == FUNC_UPDATE) && (dt_reg != '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_WRAP;
            ST_WRAP:   if (t_reg <= PI_FIX && t_reg >= PI_LO) state_next = ST_DIFF;
            ST_DIFF:   state_next = update_path ? ST_MUL_X : ST_COMMIT;
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_ADD;
            ST_ADD:    state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == '0) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_OVF;
            ST_OVF:    state_next = sub_borrow ? ST_DIV : ST_STORE;
            ST_DIV:    if (cnt_reg == '0) state_next = ST_STORE;
            ST_STORE:  state_next = (job_reg == JOB_TURN) ? ST_COMMIT : ST_SCALE;
            ST_COMMIT: state_next = ST_DONE;
            ST_DONE:   if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake and shared unit operand selection
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        sub_a   = '0;
        sub_b   = '0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_DONE:  m_valid = 1'b1;
            ST_MUL_X: begin
                mul_a = {1'b0, dx_abs[31:0]};
                mul_b = dx_abs[31:0];
            end
            ST_MUL_Y: begin
                mul_a = {1'b0, dy_abs[31:0]};
                mul_b = dy_abs[31:0];
            end
            ST_SCALE: begin
                mul_a = job_mag;
                mul_b = RATE_SCALE;
            end
            ST_SQRT: begin
                sub_a = {rem_reg[SUB_W-3:0], sh_reg[65:64]};
                sub_b = {1'b0, root_reg, 2'b01};
            end
            ST_OVF: begin
                sub_a = SUB_W'(sh_reg[53:32]);
                sub_b = SUB_W'(dt_reg);
            end
            ST_DIV: begin
                sub_a = SUB_W'({rem_reg[31:0], sh_reg[31]});
                sub_b = SUB_W'(dt_reg);
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Pose and velocity state (reset to zero)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            speed_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            turn_reg    <= '0;
            err_reg     <= 1'b0;
        end else if (state_reg == ST_STORE) begin
            unique case (job_reg)
                JOB_SPEED: speed_reg <= (ovf_reg || q_reg[31]) ? 31'h7FFF_FFFF : q_reg[30:0];
                JOB_VX:    vel_x_reg <= sat_signed;
                JOB_VY:    vel_y_reg <= sat_signed;
                JOB_TURN:  turn_reg  <= sat_signed;
                default: ;
            endcase
        end else if (state_reg == ST_COMMIT) begin
            err_reg <= (func_reg == FUNC_UPDATE) && (dt_reg == '0);
            if (func_reg != FUNC_NONE) begin
                pos_x_reg   <= nx_reg;
                pos_y_reg   <= ny_reg;
                heading_reg <= t_reg[HEAD_W-1:0];
            end
            // set pose, or update with zero dt: velocities cleared
            if (func_reg == FUNC_SET || (func_reg == FUNC_UPDATE && dt_reg == '0)) begin
                speed_reg <= '0;
                vel_x_reg <= '0;
                vel_y_reg <= '0;
                turn_reg  <= '0;
            end
        end
    end

    // Job sequencing (control)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg <= JOB_SPEED;
            cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_ADD:   begin
                    job_reg <= JOB_SPEED;
                    cnt_reg <= SQRT_STEPS;
                end
                ST_OVF:   cnt_reg <= DIV_STEPS;
                ST_SQRT,
                ST_DIV:   cnt_reg <= cnt_reg - 6'd1;
                ST_STORE: job_reg <= job_t'(job_reg + 2'd1);
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            // latch request and position steps against the old pose
            ST_IDLE: begin
                if (s_valid) begin
                    func_reg <= func_t'(s_func);
                    nx_reg   <= s_new_x;
                    ny_reg   <= s_new_y;
                    dt_reg   <= s_dt_us;
                    t_reg    <= WRAP_W'(s_new_theta);
                    dx_reg   <= (POS_W+1)'(s_new_x) - (POS_W+1)'(pos_x_reg);
                    dy_reg   <= (POS_W+1)'(s_new_y) - (POS_W+1)'(pos_y_reg);
                end
            end
            // heading wrap, one turn per cycle
            ST_WRAP: begin
                if (t_reg > PI_FIX) begin
                    t_reg <= t_reg - TWO_PI_FIX;
                end else if (t_reg < PI_LO) begin
                    t_reg <= t_reg + TWO_PI_FIX;
                end
            end
            ST_DIFF:  dth_reg <= (HEAD_W+1)'(t_reg) - (HEAD_W+1)'(heading_reg);
            // sum of squares
            ST_MUL_X: prod_reg <= mul_p;
            ST_MUL_Y: begin
                sh_reg   <= {1'b0, prod_reg};
                prod_reg <= mul_p;
            end
            ST_ADD: begin
                sh_reg   <= sh_reg + {1'b0, prod_reg};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            // square root, one bit pair per cycle
            ST_SQRT: begin
                sh_reg <= {sh_reg[63:0], 2'b00};
                if (!sub_borrow) begin
                    rem_reg  <= sub_diff[SUB_W-1:0];
                    root_reg <= {root_reg[31:0], 1'b1};
                end else begin
                    rem_reg  <= sub_a;
                    root_reg <= {root_reg[31:0], 1'b0};
                end
            end
            ST_SCALE: prod_reg <= mul_p;
            ST_LOAD:  sh_reg   <= {12'd0, num_rounded};
            // quotient of 2^32 or more saturates every rate
            ST_OVF: begin
                ovf_reg <= !sub_borrow;
                rem_reg <= SUB_W'(sh_reg[53:32]);
                q_reg   <= '0;
            end
            // restoring division, one quotient bit per cycle
            ST_DIV: begin
                sh_reg <= {sh_reg[64:0], 1'b0};
                q_reg  <= {q_reg[30:0], !sub_borrow};
                rem_reg <= sub_borrow ? sub_a : sub_diff[SUB_W-1:0];
            end
            default: ;
        endcase
    end

    // Result ports
    assign m_pos_x_out     = pos_x_reg;
    assign m_pos_y_out     = pos_y_reg;
    assign m_heading_out   = heading_reg;
    assign m_speed_out     = speed_reg;
    assign m_vel_x_out     = vel_x_reg;
    assign m_vel_y_out     = vel_y_reg;
    assign m_turn_rate_out = turn_reg;
    assign m_zero_dt_error = err_reg;

    // Checks
    `PVT_ASSERT_IMP(a_one_in_flight, m_valid, !s_ready, "request taken while result pending")
    `PVT_ASSERT_NXT(a_no_early_result, s_valid && s_ready, !m_valid, "result valid too early")
    `PVT_ASSERT_IMP(a_wrap_range, state_reg == ST_DIFF,
        t_reg <= PI_FIX && t_reg >= PI_LO, "heading outside range after wrap")
    `PVT_ASSERT_IMP(a_zero_dt_clear, m_valid && m_zero_dt_error,
        speed_reg == '0 && vel_x_reg == '0 && vel_y_reg == '0 && turn_reg == '0,
        "velocities not cleared on zero dt")
    `PVT_ASSERT_IMP(a_div_count, state_reg == ST_DIV, cnt_reg <= DIV_STEPS,
        "division step count out of range")

endmodule
